/* design/ibfp_pkg.sv */
`timescale 1ns / 1ps
package ibfp_pkg;

   localparam int IV_DEPTH  = 32;
   localparam int UN_DEPTH  = 16;
   localparam int IV_AW     = $clog2(IV_DEPTH);
   localparam int UN_AW     = $clog2(UN_DEPTH);
   localparam int IV_CNT_W  = $clog2(IV_DEPTH + 1);
   localparam int UN_CNT_W  = $clog2(UN_DEPTH + 1);
   localparam int ID_W      = 8;
   localparam int STEP_W    = 16;
   localparam int SIZE_W    = 32;
   localparam int ORD_W     = 8;
   localparam int OFF_W     = 40;
   localparam int SEQ_W     = 6;
   localparam int ALIGN_W   = 21;
   localparam int RND_CNT_W = $clog2(OFF_W + 1);

   localparam logic [1:0] CMD_LOAD_IV = 2'd0;
   localparam logic [1:0] CMD_LOAD_UN = 2'd1;
   localparam logic [1:0] CMD_PLAN    = 2'd2;

   localparam logic [1:0] SCAN_SEL = 2'd0;
   localparam logic [1:0] SCAN_RET = 2'd1;
   localparam logic [1:0] SCAN_FIT = 2'd2;

   localparam logic KIND_OFFSET = 1'b0;
   localparam logic KIND_TOTAL  = 1'b1;

   typedef struct packed {
      logic [1:0]        command;
      logic [ID_W-1:0]   item_id;
      logic [STEP_W-1:0] first_use;
      logic [STEP_W-1:0] last_use;
      logic [SIZE_W-1:0] byte_size;
      logic [ORD_W-1:0]  tie_order;
   } req_type;

   typedef struct packed {
      logic             result_kind;
      logic [ID_W-1:0]  result_id;
      logic [OFF_W-1:0] placed_offset;
      logic [OFF_W-1:0] total_size;
      logic             dropped_flag;
      logic             last_result;
   } rsp_type;

   typedef struct packed {
      logic       load_iv;
      logic       load_un;
      logic       plan_init;
      logic       scan_start;
      logic [1:0] scan_mode;
      logic       sel_take;
      logic       retire;
      logic       place_fit;
      logic       place_top;
      logic       un_place;
      logic       fin;
      logic       rnd_start;
   } ibfp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic bk_found;
      logic k_more;
      logic un_more;
   } ibfp_sts_type;

endpackage

/* design/ibfp_round.sv */
`timescale 1ns / 1ps
module ibfp_round (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ibfp_pkg::OFF_W-1:0]   x,
   input  logic [ibfp_pkg::ALIGN_W-1:0] align,
   output logic                         done,
   output logic [ibfp_pkg::OFF_W-1:0]   result
);
   import ibfp_pkg::*;

   logic                 run_ff;
   logic                 done_ff;
   logic [RND_CNT_W-1:0] cnt_ff;
   logic [OFF_W-1:0]     xs_ff;
   logic [OFF_W-1:0]     xo_ff;
   logic [ALIGN_W-1:0]   rem_ff;
   logic [ALIGN_W-1:0]   div_ff;
   logic [ALIGN_W:0]     shifted;
   logic [ALIGN_W-1:0]   rem_in;

   always_comb begin
      shifted = {rem_ff, xs_ff[OFF_W-1]};
      if (shifted >= {1'b0, div_ff}) begin
         rem_in = ALIGN_W'(shifted - {1'b0, div_ff});
      end else begin
         rem_in = shifted[ALIGN_W-1:0];
      end
   end

   assign result = (rem_ff == '0) ? xo_ff : (xo_ff + OFF_W'(div_ff) - OFF_W'(rem_ff));
   assign done   = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= RND_CNT_W'(OFF_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == RND_CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         xs_ff  <= x;
         xo_ff  <= x;
         rem_ff <= '0;
         div_ff <= (align == '0) ? ALIGN_W'(1) : align;
      end else if (run_ff) begin
         xs_ff  <= {xs_ff[OFF_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

endmodule

/* design/ibfp_ctrl.sv */
`timescale 1ns / 1ps
module ibfp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_command,
   input  ibfp_pkg::ibfp_sts_type sts,
   input  logic                   rnd_done,
   output logic                   busy,
   output ibfp_pkg::ibfp_cmd_type cmd
);
   import ibfp_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_NEXT = 4'd1;
   localparam logic [3:0] ST_SELW = 4'd2;
   localparam logic [3:0] ST_SELT = 4'd3;
   localparam logic [3:0] ST_RETW = 4'd4;
   localparam logic [3:0] ST_RETD = 4'd5;
   localparam logic [3:0] ST_FITW = 4'd6;
   localparam logic [3:0] ST_FITD = 4'd7;
   localparam logic [3:0] ST_TOPW = 4'd8;
   localparam logic [3:0] ST_UNX  = 4'd9;
   localparam logic [3:0] ST_UNW  = 4'd10;
   localparam logic [3:0] ST_FINW = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_iv = accept && (req_command == CMD_LOAD_IV);
            cmd.load_un = accept && (req_command == CMD_LOAD_UN);
            if (accept && (req_command == CMD_PLAN)) begin
               cmd.plan_init = 1'b1;
               state_in      = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (sts.k_more) begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode  = SCAN_SEL;
               state_in       = ST_SELW;
            end else begin
               state_in = ST_UNX;
            end
         end
         ST_SELW: begin
            if (sts.scan_done) state_in = ST_SELT;
         end
         ST_SELT: begin
            cmd.sel_take   = 1'b1;
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = SCAN_RET;
            state_in       = ST_RETW;
         end
         ST_RETW: begin
            if (sts.scan_done) state_in = ST_RETD;
         end
         ST_RETD: begin
            cmd.scan_start = 1'b1;
            if (sts.bk_found) begin
               cmd.retire    = 1'b1;
               cmd.scan_mode = SCAN_RET;
               state_in      = ST_RETW;
            end else begin
               cmd.scan_mode = SCAN_FIT;
               state_in      = ST_FITW;
            end
         end
         ST_FITW: begin
            if (sts.scan_done) state_in = ST_FITD;
         end
         ST_FITD: begin
            if (sts.bk_found) begin
               cmd.place_fit = 1'b1;
               state_in      = ST_NEXT;
            end else begin
               cmd.rnd_start = 1'b1;
               state_in      = ST_TOPW;
            end
         end
         ST_TOPW: begin
            if (rnd_done) begin
               cmd.place_top = 1'b1;
               state_in      = ST_NEXT;
            end
         end
         ST_UNX: begin
            cmd.rnd_start = 1'b1;
            state_in      = sts.un_more ? ST_UNW : ST_FINW;
         end
         ST_UNW: begin
            if (rnd_done) begin
               cmd.un_place = 1'b1;
               state_in     = ST_UNX;
            end
         end
         ST_FINW: begin
            if (rnd_done) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/ibfp_datapath.sv */
`timescale 1ns / 1ps
module ibfp_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  ibfp_pkg::ibfp_cmd_type       cmd,
   output ibfp_pkg::ibfp_sts_type       sts,
   input  ibfp_pkg::req_type            req_data,
   input  logic                         csr_we,
   input  logic [ibfp_pkg::ALIGN_W-1:0] csr_wdata,
   input  logic [ibfp_pkg::OFF_W-1:0]   rnd_result,
   output logic [ibfp_pkg::OFF_W-1:0]   rnd_x,
   output logic [ibfp_pkg::ALIGN_W-1:0] rnd_align,
   output logic                         rsp_valid,
   output ibfp_pkg::rsp_type            rsp_data
);
   import ibfp_pkg::*;

   logic [ID_W-1:0]   iv_id_mem    [IV_DEPTH];
   logic [STEP_W-1:0] iv_first_mem [IV_DEPTH];
   logic [STEP_W-1:0] iv_last_mem  [IV_DEPTH];
   logic [SIZE_W-1:0] iv_size_mem  [IV_DEPTH];
   logic [ORD_W-1:0]  iv_order_mem [IV_DEPTH];
   logic [STEP_W-1:0] act_last_mem [IV_DEPTH];
   logic [OFF_W-1:0]  act_off_mem  [IV_DEPTH];
   logic [SIZE_W-1:0] act_size_mem [IV_DEPTH];
   logic [ORD_W-1:0]  act_order_mem[IV_DEPTH];
   logic [OFF_W-1:0]  free_off_mem [IV_DEPTH];
   logic [SIZE_W-1:0] free_size_mem[IV_DEPTH];
   logic [SEQ_W-1:0]  free_seq_mem [IV_DEPTH];
   logic [ID_W-1:0]   un_id_mem    [UN_DEPTH];
   logic [SIZE_W-1:0] un_size_mem  [UN_DEPTH];

   logic [ID_W-1:0]   rd_iv_id;
   logic [STEP_W-1:0] rd_iv_first;
   logic [STEP_W-1:0] rd_iv_last;
   logic [SIZE_W-1:0] rd_iv_size;
   logic [ORD_W-1:0]  rd_iv_order;
   logic [STEP_W-1:0] rd_act_last;
   logic [OFF_W-1:0]  rd_act_off;
   logic [SIZE_W-1:0] rd_act_size;
   logic [ORD_W-1:0]  rd_act_order;
   logic [OFF_W-1:0]  rd_free_off;
   logic [SIZE_W-1:0] rd_free_size;
   logic [SEQ_W-1:0]  rd_free_seq;
   logic [ID_W-1:0]   rd_un_id;
   logic [SIZE_W-1:0] rd_un_size;

   logic [IV_CNT_W-1:0] iv_count_ff;
   logic [UN_CNT_W-1:0] un_count_ff;
   logic                overflowed_ff;
   logic [IV_CNT_W-1:0] k_ff;
   logic [UN_CNT_W-1:0] u_ff;
   logic [IV_DEPTH-1:0] taken_ff;
   logic [IV_DEPTH-1:0] act_valid_ff;
   logic [IV_DEPTH-1:0] free_valid_ff;
   logic [SEQ_W-1:0]    seq_next_ff;
   logic [OFF_W-1:0]    mem_top_ff;
   logic [ALIGN_W-1:0]  alignment_ff;

   logic             scan_on_ff;
   logic [IV_AW-1:0] sc_ff;
   logic             rd_on_ff;
   logic [IV_AW-1:0] rd_idx_ff;
   logic [1:0]       scan_mode_ff;

   logic              bk_found_ff;
   logic [IV_AW-1:0]  bk_idx_ff;
   logic [ID_W-1:0]   bk_id_ff;
   logic [STEP_W-1:0] bk_first_ff;
   logic [STEP_W-1:0] bk_last_ff;
   logic [SIZE_W-1:0] bk_size_ff;
   logic [ORD_W-1:0]  bk_order_ff;
   logic [SEQ_W-1:0]  bk_seq_ff;
   logic [OFF_W-1:0]  bk_off_ff;

   logic [ID_W-1:0]   cur_id_ff;
   logic [STEP_W-1:0] cur_first_ff;
   logic [STEP_W-1:0] cur_last_ff;
   logic [SIZE_W-1:0] cur_size_ff;
   logic [ORD_W-1:0]  cur_order_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic             iv_full;
   logic             un_full;
   logic             cand;
   logic             better;
   logic             free_avail;
   logic [IV_AW-1:0] free_slot;
   logic [OFF_W-1:0] place_off;
   logic             split;
   logic             free_we;
   logic [IV_AW-1:0] free_wa;
   logic [OFF_W-1:0] free_wo;
   logic [SIZE_W-1:0] free_ws;
   logic [SEQ_W-1:0] free_wq;
   logic             placing;

   assign iv_full   = (iv_count_ff >= IV_CNT_W'(IV_DEPTH));
   assign un_full   = (un_count_ff >= UN_CNT_W'(UN_DEPTH));
   assign place_off = cmd.place_fit ? bk_off_ff : rnd_result;
   assign split     = (bk_size_ff > cur_size_ff);
   assign placing   = cmd.place_fit || cmd.place_top;
   assign rnd_x     = mem_top_ff;
   assign rnd_align = alignment_ff;

   assign sts.scan_done = rd_on_ff && (rd_idx_ff == IV_AW'(IV_DEPTH - 1));
   assign sts.bk_found  = bk_found_ff;
   assign sts.k_more    = (k_ff < iv_count_ff);
   assign sts.un_more   = (u_ff < un_count_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      free_avail = 1'b0;
      free_slot  = '0;
      for (int i = IV_DEPTH - 1; i >= 0; i--) begin
         if (!free_valid_ff[i]) begin
            free_avail = 1'b1;
            free_slot  = IV_AW'(i);
         end
      end
   end

   always_comb begin
      cand   = 1'b0;
      better = 1'b0;
      case (scan_mode_ff)
         SCAN_SEL: begin
            cand   = ({1'b0, rd_idx_ff} < iv_count_ff) && !taken_ff[rd_idx_ff];
            better = !bk_found_ff || (rd_iv_first < bk_first_ff) ||
                     ((rd_iv_first == bk_first_ff) && ((rd_iv_size > bk_size_ff) ||
                      ((rd_iv_size == bk_size_ff) && (rd_iv_order < bk_order_ff))));
         end
         SCAN_RET: begin
            cand   = act_valid_ff[rd_idx_ff] && (rd_act_last < cur_first_ff);
            better = !bk_found_ff || (rd_act_last < bk_last_ff) ||
                     ((rd_act_last == bk_last_ff) && (rd_act_order < bk_order_ff));
         end
         SCAN_FIT: begin
            cand   = free_valid_ff[rd_idx_ff] && (rd_free_size >= cur_size_ff);
            better = !bk_found_ff || (rd_free_size < bk_size_ff) ||
                     ((rd_free_size == bk_size_ff) && (rd_free_seq < bk_seq_ff));
         end
         default: begin
            cand   = 1'b0;
            better = 1'b0;
         end
      endcase
   end

   always_comb begin
      free_we = 1'b0;
      free_wa = free_slot;
      free_wo = bk_off_ff;
      free_ws = bk_size_ff;
      free_wq = seq_next_ff;
      if (cmd.retire && free_avail) begin
         free_we = 1'b1;
      end else if (cmd.place_fit && split) begin
         free_we = 1'b1;
         free_wa = bk_idx_ff;
         free_wo = bk_off_ff + OFF_W'(cur_size_ff);
         free_ws = bk_size_ff - cur_size_ff;
         free_wq = bk_seq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_iv && !iv_full) begin
         iv_id_mem[iv_count_ff[IV_AW-1:0]]    <= req_data.item_id;
         iv_first_mem[iv_count_ff[IV_AW-1:0]] <= req_data.first_use;
         iv_last_mem[iv_count_ff[IV_AW-1:0]]  <= req_data.last_use;
         iv_size_mem[iv_count_ff[IV_AW-1:0]]  <= req_data.byte_size;
         iv_order_mem[iv_count_ff[IV_AW-1:0]] <= req_data.tie_order;
      end
      rd_iv_id    <= iv_id_mem[sc_ff];
      rd_iv_first <= iv_first_mem[sc_ff];
      rd_iv_last  <= iv_last_mem[sc_ff];
      rd_iv_size  <= iv_size_mem[sc_ff];
      rd_iv_order <= iv_order_mem[sc_ff];
   end

   always_ff @(posedge clock) begin
      if (placing) begin
         act_last_mem[k_ff[IV_AW-1:0]]  <= cur_last_ff;
         act_off_mem[k_ff[IV_AW-1:0]]   <= place_off;
         act_size_mem[k_ff[IV_AW-1:0]]  <= cur_size_ff;
         act_order_mem[k_ff[IV_AW-1:0]] <= cur_order_ff;
      end
      rd_act_last  <= act_last_mem[sc_ff];
      rd_act_off   <= act_off_mem[sc_ff];
      rd_act_size  <= act_size_mem[sc_ff];
      rd_act_order <= act_order_mem[sc_ff];
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_off_mem[free_wa]  <= free_wo;
         free_size_mem[free_wa] <= free_ws;
         free_seq_mem[free_wa]  <= free_wq;
      end
      rd_free_off  <= free_off_mem[sc_ff];
      rd_free_size <= free_size_mem[sc_ff];
      rd_free_seq  <= free_seq_mem[sc_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_un && !un_full) begin
         un_id_mem[un_count_ff[UN_AW-1:0]]   <= req_data.item_id;
         un_size_mem[un_count_ff[UN_AW-1:0]] <= req_data.byte_size;
      end
      rd_un_id   <= un_id_mem[u_ff[UN_AW-1:0]];
      rd_un_size <= un_size_mem[u_ff[UN_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_count_ff   <= '0;
         un_count_ff   <= '0;
         overflowed_ff <= 1'b0;
         k_ff          <= '0;
         u_ff          <= '0;
         taken_ff      <= '0;
         act_valid_ff  <= '0;
         free_valid_ff <= '0;
         seq_next_ff   <= '0;
         mem_top_ff    <= '0;
         alignment_ff  <= ALIGN_W'(1);
      end else begin
         if (csr_we) alignment_ff <= csr_wdata;
         if (cmd.load_iv) begin
            if (iv_full) overflowed_ff <= 1'b1;
            else iv_count_ff <= iv_count_ff + 1'b1;
         end
         if (cmd.load_un) begin
            if (un_full) overflowed_ff <= 1'b1;
            else un_count_ff <= un_count_ff + 1'b1;
         end
         if (cmd.plan_init) begin
            k_ff          <= '0;
            u_ff          <= '0;
            taken_ff      <= '0;
            act_valid_ff  <= '0;
            free_valid_ff <= '0;
            seq_next_ff   <= '0;
            mem_top_ff    <= '0;
         end
         if (cmd.sel_take) taken_ff[bk_idx_ff] <= 1'b1;
         if (cmd.retire) begin
            act_valid_ff[bk_idx_ff] <= 1'b0;
            if (free_avail) begin
               free_valid_ff[free_slot] <= 1'b1;
               seq_next_ff              <= seq_next_ff + 1'b1;
            end
         end
         if (cmd.place_fit && !split) free_valid_ff[bk_idx_ff] <= 1'b0;
         if (placing) begin
            act_valid_ff[k_ff[IV_AW-1:0]] <= 1'b1;
            k_ff                          <= k_ff + 1'b1;
         end
         if (cmd.place_top) mem_top_ff <= rnd_result + OFF_W'(cur_size_ff);
         if (cmd.un_place) begin
            mem_top_ff <= rnd_result + OFF_W'(rd_un_size);
            u_ff       <= u_ff + 1'b1;
         end
         if (cmd.fin) begin
            mem_top_ff    <= rnd_result;
            iv_count_ff   <= '0;
            un_count_ff   <= '0;
            overflowed_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_on_ff   <= 1'b0;
         sc_ff        <= '0;
         rd_on_ff     <= 1'b0;
         rd_idx_ff    <= '0;
         scan_mode_ff <= SCAN_SEL;
         bk_found_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_on_ff  <= scan_on_ff;
         rd_idx_ff <= sc_ff;
         if (cmd.scan_start) begin
            scan_on_ff   <= 1'b1;
            sc_ff        <= '0;
            scan_mode_ff <= cmd.scan_mode;
         end else if (scan_on_ff) begin
            sc_ff <= sc_ff + 1'b1;
            if (sc_ff == IV_AW'(IV_DEPTH - 1)) scan_on_ff <= 1'b0;
         end
         if (cmd.scan_start) begin
            bk_found_ff <= 1'b0;
         end else if (rd_on_ff && cand && better) begin
            bk_found_ff <= 1'b1;
         end
         rsp_valid_ff <= placing || cmd.un_place || cmd.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (!cmd.scan_start && rd_on_ff && cand && better) begin
         bk_idx_ff <= rd_idx_ff;
         case (scan_mode_ff)
            SCAN_SEL: begin
               bk_id_ff    <= rd_iv_id;
               bk_first_ff <= rd_iv_first;
               bk_last_ff  <= rd_iv_last;
               bk_size_ff  <= rd_iv_size;
               bk_order_ff <= rd_iv_order;
            end
            SCAN_RET: begin
               bk_last_ff  <= rd_act_last;
               bk_size_ff  <= rd_act_size;
               bk_order_ff <= rd_act_order;
               bk_off_ff   <= rd_act_off;
            end
            SCAN_FIT: begin
               bk_size_ff <= rd_free_size;
               bk_seq_ff  <= rd_free_seq;
               bk_off_ff  <= rd_free_off;
            end
            default: begin
               bk_size_ff <= bk_size_ff;
            end
         endcase
      end
      if (cmd.sel_take) begin
         cur_id_ff    <= bk_id_ff;
         cur_first_ff <= bk_first_ff;
         cur_last_ff  <= bk_last_ff;
         cur_size_ff  <= bk_size_ff;
         cur_order_ff <= bk_order_ff;
      end
      if (placing) begin
         rsp_ff <= '{result_kind: KIND_OFFSET, result_id: cur_id_ff, placed_offset: place_off,
                     total_size: '0, dropped_flag: 1'b0, last_result: 1'b0};
      end else if (cmd.un_place) begin
         rsp_ff <= '{result_kind: KIND_OFFSET, result_id: rd_un_id, placed_offset: rnd_result,
                     total_size: '0, dropped_flag: 1'b0, last_result: 1'b0};
      end else if (cmd.fin) begin
         rsp_ff <= '{result_kind: KIND_TOTAL, result_id: '0, placed_offset: '0,
                     total_size: rnd_result, dropped_flag: overflowed_ff, last_result: 1'b1};
      end
   end

   a_final_clears_stores: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_result |-> (iv_count_ff == '0) && (un_count_ff == '0))
      else $error("final transaction left loaded items in the stores");

   a_scan_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> !scan_on_ff && !rd_on_ff)
      else $error("scan restarted while a scan was still running");

   a_fit_block_large: assert property (@(posedge clock) disable iff (reset)
      cmd.place_fit |-> bk_found_ff && (bk_size_ff >= cur_size_ff))
      else $error("placement into a free block that does not fit");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (iv_count_ff <= IV_CNT_W'(IV_DEPTH)) && (un_count_ff <= UN_CNT_W'(UN_DEPTH)))
      else $error("store count out of range");

endmodule

/* design/interval_best_fit_offset_planner.sv */
`timescale 1ns / 1ps
// Buffer offset planner, best fit over a free list of retired live intervals.
// Input transactions: assert start with req_data; one is taken at a clock edge
// with start high and busy low. Load commands (interval, unseen buffer) leave
// busy low. A plan command raises busy until its last result has been sent.
// Results: each one is on rsp_data for one cycle with rsp_valid high; one per
// placed buffer in placement order, then a final one with last_result set that
// carries the aligned total and the dropped flag. The receiver cannot stall.
// Steps of a plan: each interval costs a selection scan, a retire scan for each
// retirement plus one more, and a best-fit scan; these are sweeps of the
// 32-entry stores. An interval placed at the end of memory, each unseen buffer
// and the final total also pass through the bit-serial rounding unit (one
// remainder bit per cycle).
// csr_we/csr_wdata write the alignment register (zero acts as one); write it
// only while busy is low.
// Reset empties both stores and sets alignment to one; no clearing sweep.
module interval_best_fit_offset_planner (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  ibfp_pkg::req_type            req_data,
   output logic                         rsp_valid,
   output ibfp_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [ibfp_pkg::ALIGN_W-1:0] csr_wdata
);
   import ibfp_pkg::*;

   ibfp_cmd_type       cmd;
   ibfp_sts_type       sts;
   logic               rnd_done;
   logic [OFF_W-1:0]   rnd_result;
   logic [OFF_W-1:0]   rnd_x;
   logic [ALIGN_W-1:0] rnd_align;

   ibfp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_data.command),
      .sts         (sts),
      .rnd_done    (rnd_done),
      .busy        (busy),
      .cmd         (cmd)
   );

   ibfp_round u_round (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.rnd_start),
      .x      (rnd_x),
      .align  (rnd_align),
      .done   (rnd_done),
      .result (rnd_result)
   );

   ibfp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rnd_result (rnd_result),
      .rnd_x      (rnd_x),
      .rnd_align  (rnd_align),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

/* tb/interval_best_fit_offset_planner_checker.sv */
`timescale 1ns / 1ps
module interval_best_fit_offset_planner_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  ibfp_pkg::req_type            req_data,
   input  logic                         rsp_valid,
   input  ibfp_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [ibfp_pkg::ALIGN_W-1:0] csr_wdata,
   output int                           fail_count,
   output int                           pending,
   output int                           plan_count,
   output int                           result_count
);
   import ibfp_pkg::*;

   logic [ALIGN_W-1:0] align_q;
   logic [ID_W-1:0]    ivs_id    [IV_DEPTH];
   logic [STEP_W-1:0]  ivs_first [IV_DEPTH];
   logic [STEP_W-1:0]  ivs_last  [IV_DEPTH];
   logic [SIZE_W-1:0]  ivs_size  [IV_DEPTH];
   logic [ORD_W-1:0]   ivs_ord   [IV_DEPTH];
   int                 ivs_n;
   logic [ID_W-1:0]    uns_id    [UN_DEPTH];
   logic [SIZE_W-1:0]  uns_size  [UN_DEPTH];
   int                 uns_n;
   logic               lost;
   rsp_type            offsets_due[$];

   function automatic logic [63:0] align_up(logic [63:0] x);
      logic [63:0] a;
      a = (align_q == 0) ? 64'd1 : 64'(align_q);
      return ((x + a - 1) / a) * a;
   endfunction

   function automatic bit earlier(int a, int b);
      if (ivs_first[a] != ivs_first[b]) return ivs_first[a] < ivs_first[b];
      if (ivs_size[a] != ivs_size[b]) return ivs_size[a] > ivs_size[b];
      return ivs_ord[a] < ivs_ord[b];
   endfunction

   task automatic plan_offsets();
      int               ord [IV_DEPTH];
      logic [OFF_W-1:0] fr_off [IV_DEPTH];
      logic [SIZE_W-1:0] fr_size [IV_DEPTH];
      logic [SEQ_W-1:0] fr_seq [IV_DEPTH];
      bit               fr_ok [IV_DEPTH];
      logic [STEP_W-1:0] ac_last [IV_DEPTH];
      logic [OFF_W-1:0] ac_off [IV_DEPTH];
      logic [SIZE_W-1:0] ac_size [IV_DEPTH];
      logic [ORD_W-1:0] ac_ord [IV_DEPTH];
      bit               ac_ok [IV_DEPTH];
      logic [OFF_W-1:0] top;
      logic [SEQ_W-1:0] seq_nx;
      logic [OFF_W-1:0] off;
      logic [SIZE_W-1:0] need;
      rsp_type          r;
      int               j, v, cur, rt, fs, best;
      top = '0;
      seq_nx = '0;
      for (int i = 0; i < IV_DEPTH; i++) begin
         fr_ok[i] = 0;
         ac_ok[i] = 0;
      end
      for (int i = 0; i < ivs_n; i++) begin
         v = i;
         j = i;
         while (j > 0 && earlier(v, ord[j-1])) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = v;
      end
      for (int k = 0; k < ivs_n; k++) begin
         cur = ord[k];
         need = ivs_size[cur];
         forever begin
            rt = -1;
            fs = -1;
            for (int i = 0; i < IV_DEPTH; i++) begin
               if (!ac_ok[i] || ac_last[i] >= ivs_first[cur]) continue;
               if (rt < 0 || ac_last[i] < ac_last[rt] ||
                   (ac_last[i] == ac_last[rt] && ac_ord[i] < ac_ord[rt])) rt = i;
            end
            if (rt < 0) break;
            for (int i = 0; i < IV_DEPTH; i++)
               if (!fr_ok[i]) begin
                  fs = i;
                  break;
               end
            ac_ok[rt] = 0;
            if (fs < 0) continue;
            fr_ok[fs] = 1;
            fr_off[fs] = ac_off[rt];
            fr_size[fs] = ac_size[rt];
            fr_seq[fs] = seq_nx;
            seq_nx = seq_nx + 1'b1;
         end
         best = -1;
         for (int i = 0; i < IV_DEPTH; i++) begin
            if (!fr_ok[i] || fr_size[i] < need) continue;
            if (best < 0 || fr_size[i] < fr_size[best] ||
                (fr_size[i] == fr_size[best] && fr_seq[i] < fr_seq[best])) best = i;
         end
         if (best >= 0) begin
            off = fr_off[best];
            if (fr_size[best] > need) begin
               fr_off[best] = fr_off[best] + OFF_W'(need);
               fr_size[best] = fr_size[best] - need;
            end else begin
               fr_ok[best] = 0;
            end
         end else begin
            off = OFF_W'(align_up(64'(top)));
            top = off + OFF_W'(need);
         end
         ac_ok[k] = 1;
         ac_last[k] = ivs_last[cur];
         ac_off[k] = off;
         ac_size[k] = need;
         ac_ord[k] = ivs_ord[cur];
         r = '0;
         r.result_kind = KIND_OFFSET;
         r.result_id = ivs_id[cur];
         r.placed_offset = off;
         offsets_due.push_back(r);
      end
      for (int i = 0; i < uns_n; i++) begin
         off = OFF_W'(align_up(64'(top)));
         top = off + OFF_W'(uns_size[i]);
         r = '0;
         r.result_kind = KIND_OFFSET;
         r.result_id = uns_id[i];
         r.placed_offset = off;
         offsets_due.push_back(r);
      end
      r = '0;
      r.result_kind = KIND_TOTAL;
      r.total_size = OFF_W'(align_up(64'(top)));
      r.dropped_flag = lost;
      r.last_result = 1'b1;
      offsets_due.push_back(r);
      ivs_n = 0;
      uns_n = 0;
      lost = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         align_q <= ALIGN_W'(1);
         ivs_n = 0;
         uns_n = 0;
         lost = 1'b0;
         fail_count = 0;
         plan_count = 0;
         result_count = 0;
         offsets_due.delete();
      end else begin
         if (rsp_valid) begin
            result_count++;
            if (offsets_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               want = offsets_due.pop_front();
               if (want.result_kind !== rsp_data.result_kind ||
                   want.result_id !== rsp_data.result_id ||
                   want.placed_offset !== rsp_data.placed_offset ||
                   want.total_size !== rsp_data.total_size ||
                   want.dropped_flag !== rsp_data.dropped_flag ||
                   want.last_result !== rsp_data.last_result) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
               end
            end
         end
         if (start && !busy) begin
            case (req_data.command)
               CMD_LOAD_IV: begin
                  if (ivs_n >= IV_DEPTH) lost = 1'b1;
                  else begin
                     ivs_id[ivs_n] = req_data.item_id;
                     ivs_first[ivs_n] = req_data.first_use;
                     ivs_last[ivs_n] = req_data.last_use;
                     ivs_size[ivs_n] = req_data.byte_size;
                     ivs_ord[ivs_n] = req_data.tie_order;
                     ivs_n++;
                  end
               end
               CMD_LOAD_UN: begin
                  if (uns_n >= UN_DEPTH) lost = 1'b1;
                  else begin
                     uns_id[uns_n] = req_data.item_id;
                     uns_size[uns_n] = req_data.byte_size;
                     uns_n++;
                  end
               end
               CMD_PLAN: begin
                  plan_offsets();
                  plan_count++;
               end
               default: ;
            endcase
         end
         if (csr_we) align_q <= csr_wdata;
      end
      pending <= offsets_due.size();
   end
endmodule

/* tb/tb_interval_best_fit_offset_planner.sv */
`timescale 1ns / 1ps
module tb_interval_best_fit_offset_planner;
   import ibfp_pkg::*;

   localparam int LIMIT = 3000000;
   localparam logic [1:0] CMD_IGNORED = 2'd3;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_we = 0;
   logic [ALIGN_W-1:0] csr_wdata = '0;
   int                 fail_count, pending, plan_count, result_count;
   int                 sent = 0;
   int                 cycles = 0;
   bit                 burst = 0;

   interval_best_fit_offset_planner dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   interval_best_fit_offset_planner_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending), .plan_count(plan_count),
      .result_count(result_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int pick_gap();
      if (burst || $urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   task automatic send(req_type item);
      int gap;
      gap = pick_gap();
      start <= 1;
      req_data <= item;
      do @(posedge clock); while (busy);
      sent++;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_align(logic [ALIGN_W-1:0] value);
      csr_we <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic req_type mk(logic [1:0] cmd, logic [7:0] id, logic [15:0] f,
                                  logic [15:0] l, logic [31:0] sz, logic [7:0] o);
      req_type t;
      t.command = cmd;
      t.item_id = id;
      t.first_use = f;
      t.last_use = l;
      t.byte_size = sz;
      t.tie_order = o;
      return t;
   endfunction

   function automatic req_type rand_iv();
      logic [15:0] f;
      logic [31:0] sz;
      f = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
      case ($urandom_range(0, 5))
         0: sz = $urandom;
         1: sz = 0;
         2: sz = 32'(16 << $urandom_range(0, 4));
         default: sz = $urandom_range(1, 300);
      endcase
      return mk(CMD_LOAD_IV, 8'($urandom), f,
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : f + 16'($urandom_range(0, 8)),
                sz, ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom));
   endfunction

   initial begin
      int n_iv, n_un, na;
      logic [ALIGN_W-1:0] aligns [7];
      aligns = '{21'd0, 21'd1, 21'd2, 21'd3, 21'd64, 21'd1048576, 21'h1FFFFF};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, ties, retirement, zero size, ignored command
      send(mk(CMD_LOAD_IV, 8'd0, 16'd0, 16'd0, 32'd100, 8'd5));
      send(mk(CMD_LOAD_IV, 8'd255, 16'd0, 16'd0, 32'd100, 8'd5));
      send(mk(CMD_LOAD_IV, 8'd7, 16'd0, 16'd2, 32'd40, 8'd255));
      send(mk(CMD_LOAD_IV, 8'd8, 16'd3, 16'd9, 32'd60, 8'd0));
      send(mk(CMD_LOAD_IV, 8'd9, 16'd3, 16'd4, 32'd0, 8'd1));
      send(mk(CMD_LOAD_IV, 8'd10, 16'd5, 16'd65535, 32'd30, 8'd2));
      send(mk(CMD_LOAD_IV, 8'd11, 16'd65535, 16'd65535, 32'hFFFFFFFF, 8'd3));
      send(mk(CMD_IGNORED, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 8'hFF));
      send(mk(CMD_LOAD_UN, 8'd12, 16'd0, 16'd0, 32'd0, 8'd0));
      send(mk(CMD_LOAD_UN, 8'd12, 16'd0, 16'd0, 32'hFFFFFFFF, 8'd0));
      send(mk(CMD_PLAN, 8'd0, 16'd0, 16'd0, 32'd0, 8'd0));
      drain();
      set_align(21'd0);
      send(mk(CMD_LOAD_UN, 8'd1, 16'd0, 16'd0, 32'd3, 8'd0));
      send(mk(CMD_LOAD_UN, 8'd2, 16'd0, 16'd0, 32'd5, 8'd0));
      send(mk(CMD_PLAN, 8'd0, 16'd0, 16'd0, 32'd0, 8'd0));
      send(mk(CMD_PLAN, 8'd0, 16'd0, 16'd0, 32'd0, 8'd0));
      drain();
      set_align(21'h1FFFFF);
      send(mk(CMD_LOAD_IV, 8'd3, 16'd0, 16'd0, 32'd1, 8'd0));
      send(mk(CMD_LOAD_UN, 8'd4, 16'd0, 16'd0, 32'd1, 8'd0));
      send(mk(CMD_PLAN, 8'd0, 16'd0, 16'd0, 32'd0, 8'd0));
      drain();

      while (sent < 500) begin
         na = $urandom_range(0, 9);
         set_align(na < 7 ? aligns[na] : 21'($urandom));
         burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) begin
            n_iv = $urandom_range(32, 35);
            n_un = $urandom_range(15, 18);
         end else begin
            n_iv = $urandom_range(0, 10);
            n_un = $urandom_range(0, 4);
         end
         while (n_iv > 0 || n_un > 0) begin
            if ($urandom_range(0, 19) == 0)
               send(mk(CMD_IGNORED, 8'($urandom), 16'($urandom), 16'($urandom),
                       $urandom, 8'($urandom)));
            if (n_un > 0 && (n_iv == 0 || $urandom_range(0, 3) == 0)) begin
               send(mk(CMD_LOAD_UN, 8'($urandom), 16'($urandom), 16'($urandom),
                       ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 200),
                       8'($urandom)));
               n_un--;
            end else begin
               send(rand_iv());
               n_iv--;
            end
         end
         send(mk(CMD_PLAN, 8'($urandom), 16'($urandom), 16'($urandom), $urandom,
                 8'($urandom)));
         if ($urandom_range(0, 3) == 0)
            send(mk(CMD_PLAN, 8'd0, 16'd0, 16'd0, 32'd0, 8'd0));
         drain();
      end

      drain();
      $display("covered %0d transactions, %0d plans, %0d results checked",
               sent, plan_count, result_count);
      $display("alignment swept over zero, one, odd, power-of-two and maximum values");
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
